@@ rtl/uaps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB audio isochronous packet sizer package
// Shared widths, constants, status codes and sequencer states.
// ----------------------------------------------------------------------------
package uaps_pkg;

  localparam int RATE_W    = 22;
  localparam int IVAL_W    = 25;
  localparam int FBYTES_W  = 11;
  localparam int PAYLOAD_W = 13;
  localparam int PEND_W    = 23;
  localparam int REM_W     = 20;
  localparam int QUO_W     = 28;
  localparam int ACC_W     = 47;
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 25;

  localparam logic [REM_W-1:0]  US_PER_S  = REM_W'(1000000);
  localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};

  // The reciprocal of one million scaled by 2^44 leaves the estimate at most
  // one below the true quotient for every 47-bit dividend.
  localparam int DIV_SHIFT = 44;
  localparam int DIV_A_LSB = ACC_W - MUL_A_W;
  localparam int DIV_Q_LSB = DIV_SHIFT - DIV_A_LSB;
  localparam logic [MUL_B_W-1:0] DIV_RECIP = MUL_B_W'((64'd1 << DIV_SHIFT) / 64'd1000000);

  localparam logic [MUL_B_W-1:0] FB10_MULT  = MUL_B_W'(1000);
  localparam logic [MUL_B_W-1:0] FB16_MULT  = MUL_B_W'(125);
  localparam logic [REM_W-1:0]   FB10_ROUND = REM_W'(8192);
  localparam logic [REM_W-1:0]   FB16_ROUND = REM_W'(512);

  localparam logic [RATE_W-1:0]    NOMINAL_RESET = RATE_W'(48000);
  localparam logic [IVAL_W-1:0]    IVAL_RESET    = IVAL_W'(1000);
  localparam logic [FBYTES_W-1:0]  FBYTES_RESET  = FBYTES_W'(4);
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = PAYLOAD_W'(192);

  typedef enum logic [1:0] {
    CMD_PACKET   = 2'd0,
    CMD_FEEDBACK = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ISSUED     = 3'd0,
    ST_SHORT      = 3'd1,
    ST_RANGE      = 3'd2,
    ST_FB_TAKEN   = 3'd3,
    ST_FB_IGNORED = 3'd4,
    ST_CLEARED    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_NOMINAL = 2'd0,
    REG_IVAL    = 2'd1,
    REG_FBYTES  = 2'd2,
    REG_PAYLOAD = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_EST,
    S_REM,
    S_FIX,
    S_SCALE,
    S_CHECK,
    S_FB,
    S_FBSAT,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MSEL_RATE,
    MSEL_FRAMES,
    MSEL_FB,
    MSEL_RECIP,
    MSEL_BACK
  } msel_t;

endpackage

@@ rtl/usb_audio_iso_packet_sizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB audio isochronous packet sizer
// Sizes isochronous OUT packets from the sample rate, service interval and
// frame size, tracks the fractional frame remainder and decodes feedback.
// ----------------------------------------------------------------------------
// Requests enter on the req channel (cmd, pending_bytes, feedback_word,
// feedback_bytes) and each transaction yields exactly one result on the rsp
// channel (status, packet_bytes, effective_rate). A transaction is taken
// when valid is high and stall is low.
// The block works on one request at a time and raises req_stall while busy.
// A packet request passes through the accepting state, one multiply-add, a
// reciprocal estimate of the quotient by one million, a back-multiply that
// forms the remainder, one correction step, one multiply by the frame size,
// one range check and the load of the result register. A feedback word of
// 3 or more bytes passes through a multiply-add and a saturation step
// before that load; a shorter one, a remainder clear or an unknown command
// goes straight from acceptance to the load. All multiplies share a single
// 32 x 25 multiplier.
// A finished result waits in the output register while rsp_stall is high;
// the block takes the next request meanwhile and holds its following result
// until the register is free. The user writes configuration via the APB port
// only while the block is idle (unenforced). Reset restores the register
// defaults and clears remainder and feedback state; no clearing pass needed.
// ----------------------------------------------------------------------------
module usb_audio_iso_packet_sizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [1:0]                     cmd,
  input  logic [uaps_pkg::PEND_W-1:0]    pending_bytes,
  input  logic [31:0]                    feedback_word,
  input  logic [2:0]                     feedback_bytes,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [2:0]                     status,
  output logic [uaps_pkg::PAYLOAD_W-1:0] packet_bytes,
  output logic [uaps_pkg::RATE_W-1:0]    effective_rate,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import uaps_pkg::*;

  logic [RATE_W-1:0]    nominal_rate_hz;
  logic [IVAL_W-1:0]    interval_us;
  logic [FBYTES_W-1:0]  frame_bytes;
  logic [PAYLOAD_W-1:0] max_payload;

  logic [REM_W-1:0]  frame_remainder;
  logic              fb_seen;
  logic [RATE_W-1:0] fb_rate;
  logic [RATE_W-1:0] cur_rate;

  state_t state, state_next;

  logic [PEND_W-1:0] pend;
  logic [31:0]       raw;
  logic              fb_ten;
  logic [REM_W-1:0]  dpart;
  logic [QUO_W-1:0]  dquo;
  logic [REM_W:0]    rwide;
  logic [ACC_W-1:0]  acc;
  status_t           res_status;
  logic [PAYLOAD_W-1:0] res_bytes;

  msel_t               msel;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [REM_W-1:0]    addend;
  logic [MUL_A_W+MUL_B_W-1:0] mul_p;
  logic [ACC_W-1:0]    mac;

  logic [ACC_W-1:0] rdiff;
  logic             rfix;
  logic             out_free;
  logic             cfg_wr;
  logic [ACC_W-15:0] fb_shift14;
  logic [ACC_W-11:0] fb_shift10;
  logic [ACC_W-11:0] fb_scaled;
  logic [RATE_W-1:0] fb_sat;
  logic [ACC_W-9:0]  bytes;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cur_rate = fb_seen ? fb_rate : nominal_rate_hz;
  assign out_free = !(rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_rate_hz <= NOMINAL_RESET;
      interval_us     <= IVAL_RESET;
      frame_bytes     <= FBYTES_RESET;
      max_payload     <= PAYLOAD_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_NOMINAL: nominal_rate_hz <= pwdata[RATE_W-1:0];
        REG_IVAL:    interval_us     <= pwdata[IVAL_W-1:0];
        REG_FBYTES:  frame_bytes     <= pwdata[FBYTES_W-1:0];
        REG_PAYLOAD: max_payload     <= pwdata[PAYLOAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_NOMINAL: prdata = 32'(nominal_rate_hz);
      REG_IVAL:    prdata = 32'(interval_us);
      REG_FBYTES:  prdata = 32'(frame_bytes);
      REG_PAYLOAD: prdata = 32'(max_payload);
      default:     prdata = '0;
    endcase
  end

  // Shared multiply-add unit.
  assign mul_p = (MUL_A_W+MUL_B_W)'(mul_a) * (MUL_A_W+MUL_B_W)'(mul_b);
  assign mac   = mul_p[ACC_W-1:0] + ACC_W'(addend);

  // The estimated quotient is low by at most one, so one compare and
  // subtract on the remainder finishes the division by one million.
  assign rdiff = acc - mul_p[ACC_W-1:0];
  assign rfix  = rwide >= {1'b0, US_PER_S};

  assign fb_shift14 = acc[ACC_W-1:14];
  assign fb_shift10 = acc[ACC_W-1:10];
  assign fb_scaled  = fb_ten ? (ACC_W-10)'(fb_shift14) : fb_shift10;
  assign fb_sat     = (fb_scaled > (ACC_W-10)'(RATE_MAX)) ? RATE_MAX
                                                          : fb_scaled[RATE_W-1:0];
  assign bytes      = acc[ACC_W-9:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          priority case (cmd_t'(cmd))
            CMD_PACKET:   state_next = S_MUL;
            CMD_FEEDBACK: state_next = (feedback_bytes >= 3'd3) ? S_FB : S_DONE;
            default:      state_next = S_DONE;
          endcase
        end
      end
      S_MUL:   state_next = S_EST;
      S_EST:   state_next = S_REM;
      S_REM:   state_next = S_FIX;
      S_FIX:   state_next = S_SCALE;
      S_SCALE: state_next = S_CHECK;
      S_CHECK: state_next = S_DONE;
      S_FB:    state_next = S_FBSAT;
      S_FBSAT: state_next = S_DONE;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != S_IDLE);
    msel      = MSEL_RATE;
    unique case (state)
      S_EST:   msel = MSEL_RECIP;
      S_REM:   msel = MSEL_BACK;
      S_SCALE: msel = MSEL_FRAMES;
      S_FB:    msel = MSEL_FB;
      default: msel = MSEL_RATE;
    endcase
    unique case (msel)
      MSEL_RATE: begin
        mul_a  = MUL_A_W'(cur_rate);
        mul_b  = interval_us;
        addend = frame_remainder;
      end
      MSEL_RECIP: begin
        mul_a  = acc[ACC_W-1:DIV_A_LSB];
        mul_b  = DIV_RECIP;
        addend = '0;
      end
      MSEL_BACK: begin
        mul_a  = MUL_A_W'(dquo);
        mul_b  = MUL_B_W'(US_PER_S);
        addend = '0;
      end
      MSEL_FRAMES: begin
        mul_a  = MUL_A_W'(dquo);
        mul_b  = MUL_B_W'(frame_bytes);
        addend = '0;
      end
      MSEL_FB: begin
        mul_a  = raw;
        mul_b  = fb_ten ? FB10_MULT : FB16_MULT;
        addend = fb_ten ? FB10_ROUND : FB16_ROUND;
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        addend = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      frame_remainder <= '0;
      fb_seen         <= 1'b0;
      fb_rate         <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            pend      <= pending_bytes;
            fb_ten    <= (feedback_bytes == 3'd3);
            raw       <= (feedback_bytes == 3'd3) ? {8'd0, feedback_word[23:0]}
                                                  : feedback_word;
            res_bytes <= '0;
            unique case (cmd_t'(cmd))
              CMD_CLEAR: begin
                frame_remainder <= '0;
                res_status      <= ST_CLEARED;
              end
              default: res_status <= ST_FB_IGNORED;
            endcase
          end
        end
        S_MUL: acc <= mac;
        S_EST: dquo <= mul_p[DIV_Q_LSB+QUO_W-1:DIV_Q_LSB];
        S_REM: rwide <= rdiff[REM_W:0];
        S_FIX: begin
          if (rfix) begin
            dquo  <= dquo + QUO_W'(1);
            dpart <= REM_W'(rwide - {1'b0, US_PER_S});
          end else begin
            dpart <= rwide[REM_W-1:0];
          end
        end
        S_SCALE: acc <= mac;
        S_CHECK: begin
          if (bytes == '0 || bytes > (ACC_W-8)'(max_payload)) begin
            res_status <= ST_RANGE;
          end else if (bytes > (ACC_W-8)'(pend)) begin
            res_status <= ST_SHORT;
          end else begin
            res_status      <= ST_ISSUED;
            res_bytes       <= bytes[PAYLOAD_W-1:0];
            frame_remainder <= dpart;
          end
        end
        S_FB: acc <= mac;
        S_FBSAT: begin
          if (raw != '0) begin
            fb_rate    <= fb_sat;
            fb_seen    <= 1'b1;
            res_status <= ST_FB_TAKEN;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid      <= 1'b1;
            status         <= res_status;
            packet_bytes   <= res_bytes;
            effective_rate <= cur_rate;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    frame_remainder < US_PER_S)
    else $error("frame remainder reached one million");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (rsp_valid && state == S_IDLE))
    else $error("finished transaction did not reach the output register");

  a_issued_size: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_ISSUED) |-> (packet_bytes != '0 && packet_bytes <= max_payload))
    else $error("issued packet size out of range");

  a_other_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_ISSUED) |-> (packet_bytes == '0))
    else $error("packet size nonzero on a packet that was not issued");
`endif

endmodule

@@ tb/usb_audio_iso_packet_sizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB audio isochronous packet sizer testbench
// Drives packet requests, feedback words and remainder clears through the
// request channel and checks every response against a cycle-free predictor
// of the sizing, remainder and feedback decoding rules, or a directed row's
// stated result. A short table of directed rows runs first; random phases
// with changing register settings and random idling on both channels follow.
// ----------------------------------------------------------------------------
module usb_audio_iso_packet_sizer_tb;
  import uaps_pkg::*;

  localparam int unsigned GAP_MAX      = 6;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned PRINT_MAX    = 30;
  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  typedef struct {
    cmd_t                cmd;
    logic [PEND_W-1:0]   pend;
    logic [31:0]         word;
    logic [2:0]          fb_len;
  } req_t;

  typedef struct {
    status_t              st;
    logic [PAYLOAD_W-1:0] nbytes;
    logic [RATE_W-1:0]    hz;
  } rsp_t;

  typedef struct {
    bit          is_reg;
    reg_idx_t    idx;
    logic [31:0] val;
    req_t        req;
    bit          known;
    rsp_t        want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  logic [1:0]           cmd;
  logic [PEND_W-1:0]    pending_bytes;
  logic [31:0]          feedback_word;
  logic [2:0]           feedback_bytes;
  logic                 rsp_valid;
  logic                 rsp_stall;
  logic [2:0]           status;
  logic [PAYLOAD_W-1:0] packet_bytes;
  logic [RATE_W-1:0]    effective_rate;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [3:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  logic [RATE_W-1:0]    cfg_nom_hz;
  logic [IVAL_W-1:0]    cfg_ival_us;
  logic [FBYTES_W-1:0]  cfg_frame_sz;
  logic [PAYLOAD_W-1:0] cfg_max_pl;
  logic [REM_W-1:0]     frac_acc;
  bit                   fb_locked;
  logic [RATE_W-1:0]    fb_hz;

  rsp_t        awaited_results[$];
  row_t        plan[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          long_hold   = 1'b0;

  usb_audio_iso_packet_sizer i_dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .cmd            (cmd),
    .pending_bytes  (pending_bytes),
    .feedback_word  (feedback_word),
    .feedback_bytes (feedback_bytes),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .packet_bytes   (packet_bytes),
    .effective_rate (effective_rate),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("usb_audio_iso_packet_sizer_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [RATE_W-1:0] rate_in_force();
    return fb_locked ? fb_hz : cfg_nom_hz;
  endfunction

  // Applies one request to the shadow state and returns the response it earns.
  function automatic rsp_t apply_request(req_t r);
    rsp_t        o;
    logic [63:0] scaled;
    logic [63:0] frames;
    logic [63:0] nbytes;
    logic [63:0] raw;
    logic [63:0] dec;
    o.st     = ST_FB_IGNORED;
    o.nbytes = '0;
    case (r.cmd)
      CMD_PACKET: begin
        scaled = 64'(rate_in_force()) * 64'(cfg_ival_us) + 64'(frac_acc);
        frames = scaled / 64'(US_PER_S);
        nbytes = frames * 64'(cfg_frame_sz);
        if (nbytes == 0 || nbytes > 64'(cfg_max_pl)) begin
          o.st = ST_RANGE;
        end else if (nbytes > 64'(r.pend)) begin
          o.st = ST_SHORT;
        end else begin
          o.st     = ST_ISSUED;
          o.nbytes = nbytes[PAYLOAD_W-1:0];
          frac_acc = REM_W'(scaled % 64'(US_PER_S));
        end
      end
      CMD_FEEDBACK: begin
        if (r.fb_len >= 3) begin
          if (r.fb_len == 3) begin
            raw = 64'(r.word[23:0]);
            dec = (raw * 64'(FB10_MULT) + 64'(FB10_ROUND)) >> 14;
          end else begin
            raw = 64'(r.word);
            dec = (raw * 64'(FB16_MULT) + 64'(FB16_ROUND)) >> 10;
          end
          if (raw != 0) begin
            fb_hz     = (dec > 64'(RATE_MAX)) ? RATE_MAX : dec[RATE_W-1:0];
            fb_locked = 1'b1;
            o.st      = ST_FB_TAKEN;
          end
        end
      end
      CMD_CLEAR: begin
        frac_acc = '0;
        o.st     = ST_CLEARED;
      end
      default: begin
      end
    endcase
    o.hz = rate_in_force();
    return o;
  endfunction

  function automatic row_t item_row(cmd_t c, int unsigned pend, logic [31:0] w,
                                    int unsigned len);
    row_t row;
    row.is_reg      = 1'b0;
    row.idx         = REG_NOMINAL;
    row.val         = '0;
    row.req.cmd     = c;
    row.req.pend    = PEND_W'(pend);
    row.req.word    = w;
    row.req.fb_len  = 3'(len);
    row.known       = 1'b0;
    row.want.st     = ST_ISSUED;
    row.want.nbytes = '0;
    row.want.hz     = '0;
    return row;
  endfunction

  function automatic row_t known_row(cmd_t c, int unsigned pend, logic [31:0] w,
                                     int unsigned len, status_t s, int unsigned nb,
                                     int unsigned hz);
    row_t row;
    row             = item_row(c, pend, w, len);
    row.known       = 1'b1;
    row.want.st     = s;
    row.want.nbytes = PAYLOAD_W'(nb);
    row.want.hz     = RATE_W'(hz);
    return row;
  endfunction

  function automatic row_t reg_row(reg_idx_t i, logic [31:0] v);
    row_t row;
    row        = item_row(CMD_PACKET, 0, '0, 0);
    row.is_reg = 1'b1;
    row.idx    = i;
    row.val    = v;
    return row;
  endfunction

  function automatic void add_row(row_t row);
    plan.insert(plan.size(), row);
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < PRINT_MAX) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic send_request(input req_t r, input bit known, input rsp_t want);
    int unsigned gap;
    rsp_t        got;
    gap = $urandom_range(0, GAP_MAX);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid      <= 1'b1;
    cmd            <= r.cmd;
    pending_bytes  <= r.pend;
    feedback_word  <= r.word;
    feedback_bytes <= r.fb_len;
    do @(posedge clk); while (req_stall);
    got = apply_request(r);
    awaited_results.insert(awaited_results.size(), known ? want : got);
  endtask

  // Lowers the request valid and lets every outstanding transaction drain.
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_NOMINAL: cfg_nom_hz   = val[RATE_W-1:0];
      REG_IVAL:    cfg_ival_us  = val[IVAL_W-1:0];
      REG_FBYTES:  cfg_frame_sz = val[FBYTES_W-1:0];
      REG_PAYLOAD: cfg_max_pl   = val[PAYLOAD_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic walk_rows(input int unsigned first, input int unsigned last);
    for (int unsigned i = first; i < last; i++) begin
      if (plan[i].is_reg) begin
        settle();
        reg_write(plan[i].idx, plan[i].val);
      end else begin
        send_request(plan[i].req, plan[i].known, plan[i].want);
      end
    end
  endtask

  task automatic run_phase(input bit with_fb, input int unsigned n_items, input bit squeeze);
    longint unsigned target;
    longint unsigned est;
    longint unsigned ival;
    longint unsigned fsz;
    longint unsigned pl;
    longint unsigned nom;
    longint unsigned hi;
    longint signed   raw;
    int unsigned     k;
    req_t            r;
    rsp_t            none;
    case ($urandom_range(0, 7))
      0: ival = 125;
      1: ival = 250;
      2: ival = 500;
      3, 4: ival = 1000;
      5: ival = 2000;
      6: ival = $urandom_range(125, 8000);
      default: ival = $urandom_range(0, (1 << IVAL_W) - 1);
    endcase
    fsz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, (1 << FBYTES_W) - 1)
                                      : $urandom_range(1, 32);
    target = ($urandom_range(0, 7) == 0) ? $urandom_range(0, RATE_MAX)
                                         : $urandom_range(8000, 384000);
    nom = with_fb ? $urandom_range(0, RATE_MAX) : target;
    est = (target * ival / 1000000 + 1) * fsz;
    if ($urandom_range(0, 7) == 0) begin
      pl = $urandom_range(0, (1 << PAYLOAD_W) - 1);
    end else begin
      pl = est + $urandom_range(0, 16);
      if (pl > (1 << PAYLOAD_W) - 1) pl = (1 << PAYLOAD_W) - 1;
    end
    hi = est * 2 + 8;
    if (hi > PEND_MAX) hi = PEND_MAX;
    none.st     = ST_ISSUED;
    none.nbytes = '0;
    none.hz     = '0;
    settle();
    reg_write(REG_NOMINAL, 32'(nom));
    reg_write(REG_IVAL, 32'(ival));
    reg_write(REG_FBYTES, 32'(fsz));
    reg_write(REG_PAYLOAD, 32'(pl));
    for (int unsigned i = 0; i < n_items; i++) begin
      r.pend   = PEND_W'($urandom);
      r.word   = $urandom;
      r.fb_len = 3'($urandom);
      k        = $urandom_range(0, 99);
      if (k < 65) begin
        r.cmd = CMD_PACKET;
        if ($urandom_range(0, 7) != 0) r.pend = PEND_W'($urandom_range(0, 32'(hi)));
      end else if (k < 80 && with_fb) begin
        r.cmd    = CMD_FEEDBACK;
        r.fb_len = 3'($urandom_range(3, 7));
        if (r.fb_len == 3) raw = longint'(target * 16384 / 1000);
        else raw = longint'(target * 65536 / 8000);
        raw = raw + longint'($urandom_range(0, 128)) - 64;
        if (raw < 1) raw = 1;
        if (r.fb_len == 3) r.word[23:0] = raw[23:0];
        else r.word = raw[31:0];
      end else if (k < 88) begin
        r.cmd = CMD_FEEDBACK;
        if (!with_fb) begin
          if (r.fb_len == 3) r.word[23:0] = '0;
          else if (r.fb_len > 3) r.word = '0;
        end
      end else if (k < 94) begin
        r.cmd = CMD_CLEAR;
      end else begin
        r.cmd = CMD_UNUSED;
      end
      send_request(r, 1'b0, none);
      if (squeeze && i == 4) long_hold = 1'b1;
    end
  endtask

  initial begin : receiver
    int unsigned n;
    rsp_t        want;
    rsp_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        n         = HOLD_CYCLES;
        long_hold = 1'b0;
      end else begin
        n = $urandom_range(0, GAP_MAX);
      end
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(negedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (rsp_valid !== 1'b1);
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("response with nothing awaited, status %0d", status));
      end else begin
        want = awaited_results.pop_front();
        if (status !== 3'(want.st)) begin
          note_mismatch($sformatf("status %0d, expected %0d", status, want.st));
        end
        if (packet_bytes !== want.nbytes) begin
          note_mismatch($sformatf("packet_bytes %0d, expected %0d", packet_bytes,
                                  want.nbytes));
        end
        if (effective_rate !== want.hz) begin
          note_mismatch($sformatf("effective_rate %0d, expected %0d", effective_rate,
                                  want.hz));
        end
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned split;
    rst            = 1'b1;
    req_valid      = 1'b0;
    cmd            = CMD_PACKET;
    pending_bytes  = '0;
    feedback_word  = '0;
    feedback_bytes = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_nom_hz     = NOMINAL_RESET;
    cfg_ival_us    = IVAL_RESET;
    cfg_frame_sz   = FBYTES_RESET;
    cfg_max_pl     = PAYLOAD_RESET;
    frac_acc       = '0;
    fb_locked      = 1'b0;
    fb_hz          = '0;

    // Reset defaults: 48000 Hz over 1000 us gives exactly 48 frames of 4 bytes.
    add_row(known_row(CMD_PACKET, 192, '0, 0, ST_ISSUED, 192, 48000));
    add_row(known_row(CMD_PACKET, 191, '0, 0, ST_SHORT, 0, 48000));
    add_row(known_row(CMD_PACKET, PEND_MAX, '1, 7, ST_ISSUED, 192, 48000));
    add_row(known_row(CMD_PACKET, 0, '0, 0, ST_SHORT, 0, 48000));
    add_row(known_row(CMD_FEEDBACK, 0, '1, 0, ST_FB_IGNORED, 0, 48000));
    add_row(known_row(CMD_FEEDBACK, 0, 32'hFF00_0000, 3, ST_FB_IGNORED, 0, 48000));
    add_row(known_row(CMD_FEEDBACK, 0, '0, 4, ST_FB_IGNORED, 0, 48000));
    add_row(known_row(CMD_UNUSED, PEND_MAX, '1, 7, ST_FB_IGNORED, 0, 48000));
    add_row(known_row(CMD_CLEAR, 0, '0, 0, ST_CLEARED, 0, 48000));
    add_row(reg_row(REG_NOMINAL, 32'(RATE_MAX)));
    add_row(known_row(CMD_PACKET, PEND_MAX, '0, 0, ST_RANGE, 0, RATE_MAX));
    add_row(reg_row(REG_NOMINAL, 32'd1));
    add_row(known_row(CMD_PACKET, PEND_MAX, '0, 0, ST_RANGE, 0, 1));
    add_row(reg_row(REG_NOMINAL, 32'd44100));
    add_row(reg_row(REG_PAYLOAD, 32'd8191));
    add_row(known_row(CMD_PACKET, 176, '0, 0, ST_ISSUED, 176, 44100));
    add_row(reg_row(REG_IVAL, 32'd0));
    add_row(known_row(CMD_PACKET, PEND_MAX, '0, 0, ST_RANGE, 0, 44100));
    add_row(reg_row(REG_IVAL, 32'((1 << IVAL_W) - 1)));
    add_row(reg_row(REG_FBYTES, 32'd0));
    add_row(known_row(CMD_PACKET, PEND_MAX, '0, 0, ST_RANGE, 0, 44100));
    add_row(reg_row(REG_FBYTES, 32'd1024));
    add_row(reg_row(REG_IVAL, 32'd125));
    add_row(reg_row(REG_PAYLOAD, 32'd0));
    add_row(known_row(CMD_PACKET, PEND_MAX, '0, 0, ST_RANGE, 0, 44100));
    add_row(reg_row(REG_PAYLOAD, 32'd8191));
    add_row(item_row(CMD_PACKET, PEND_MAX, '0, 0));
    add_row(reg_row(REG_NOMINAL, 32'(NOMINAL_RESET)));
    add_row(reg_row(REG_IVAL, 32'(IVAL_RESET)));
    add_row(reg_row(REG_FBYTES, 32'(FBYTES_RESET)));
    add_row(reg_row(REG_PAYLOAD, 32'(PAYLOAD_RESET)));
    add_row(known_row(CMD_CLEAR, 0, '0, 0, ST_CLEARED, 0, 48000));
    split = plan.size();
    // Feedback rows: once a word is taken, the nominal rate no longer applies.
    add_row(reg_row(REG_NOMINAL, 32'(NOMINAL_RESET)));
    add_row(reg_row(REG_IVAL, 32'(IVAL_RESET)));
    add_row(reg_row(REG_FBYTES, 32'(FBYTES_RESET)));
    add_row(reg_row(REG_PAYLOAD, 32'(PAYLOAD_RESET)));
    add_row(known_row(CMD_FEEDBACK, 0, 32'h000C_0000, 3, ST_FB_TAKEN, 0, 48000));
    add_row(known_row(CMD_FEEDBACK, 0, '1, 3, ST_FB_TAKEN, 0, 1024000));
    add_row(known_row(CMD_PACKET, PEND_MAX, '0, 0, ST_RANGE, 0, 1024000));
    add_row(known_row(CMD_FEEDBACK, 0, '1, 4, ST_FB_TAKEN, 0, RATE_MAX));
    add_row(known_row(CMD_FEEDBACK, 0, 32'd1, 7, ST_FB_TAKEN, 0, 0));
    add_row(known_row(CMD_PACKET, PEND_MAX, '0, 0, ST_RANGE, 0, 0));
    add_row(known_row(CMD_FEEDBACK, 0, 32'h0006_0000, 5, ST_FB_TAKEN, 0, 48000));
    add_row(known_row(CMD_FEEDBACK, 0, 32'h0005_8333, 2, ST_FB_IGNORED, 0, 48000));
    add_row(known_row(CMD_CLEAR, 0, '0, 0, ST_CLEARED, 0, 48000));
    add_row(known_row(CMD_PACKET, 192, '0, 0, ST_ISSUED, 192, 48000));
    add_row(item_row(CMD_FEEDBACK, 0, 32'h0005_8333, 6));
    add_row(item_row(CMD_PACKET, 200, '0, 0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    walk_rows(0, split);
    for (int p = 0; p < 4; p++) run_phase(1'b0, 50, 1'b0);
    walk_rows(split, plan.size());
    for (int p = 0; p < 12; p++) run_phase(1'b1, 120, p == 2);

    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("usb_audio_iso_packet_sizer_tb: PASS");
    end else begin
      $display("usb_audio_iso_packet_sizer_tb: FAIL");
    end
    $finish;
  end

endmodule
